// ----- rtl/jsp_pkg.sv -----
// Package for the single-pair JSON parser.
// Holds the byte codes, the result codes, the parse phase type and the character class functions.
// Has no dependencies.
package jsp_pkg;

    // longest string body, escape bytes included
    localparam int MAX_STRING_LEN = 64;
    localparam int CNT_W          = $clog2(MAX_STRING_LEN + 1);

    // text bytes
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // result kinds
    localparam logic [1:0] KIND_NAME   = 2'd0;
    localparam logic [1:0] KIND_STRING = 2'd1;
    localparam logic [1:0] KIND_ENUM   = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // enum word codes
    localparam logic [1:0] WORD_TRUE  = 2'd0;
    localparam logic [1:0] WORD_FALSE = 2'd1;
    localparam logic [1:0] WORD_NULL  = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_MISC       = 3'd1;
    localparam logic [2:0] ST_BAD_START  = 3'd2;
    localparam logic [2:0] ST_BAD_STRING = 3'd3;
    localparam logic [2:0] ST_BAD_ENUM   = 3'd4;
    localparam logic [2:0] ST_BAD_TRAIL  = 3'd5;

    // parse phase, one-hot
    typedef enum logic [11:0] {
        PH_BRACE    = 12'b0000_0000_0001,
        PH_QUOTE    = 12'b0000_0000_0010,
        PH_NAME     = 12'b0000_0000_0100,
        PH_NAME_ESC = 12'b0000_0000_1000,
        PH_COLON    = 12'b0000_0001_0000,
        PH_VALUE    = 12'b0000_0010_0000,
        PH_STR      = 12'b0000_0100_0000,
        PH_STR_ESC  = 12'b0000_1000_0000,
        PH_WORD     = 12'b0001_0000_0000,
        PH_TRAIL    = 12'b0010_0000_0000,
        PH_DONE     = 12'b0100_0000_0000,
        PH_ERROR    = 12'b1000_0000_0000
    } t_phase;

    // one result item
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload;
        logic [2:0] status;
        logic       done_res;
    } t_result;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h41) && (b <= 8'h46)) ||
               ((b >= 8'h61) && (b <= 8'h66));
    endfunction

    function automatic logic is_single_esc(input logic [7:0] b);
        return (b == CH_QUOTE) || (b == CH_BSLASH) || (b == CH_SLASH) || (b == CH_B) ||
               (b == CH_F) || (b == CH_N) || (b == CH_R) || (b == CH_T);
    endfunction

    // letters in each enum word
    function automatic logic [2:0] word_len(input logic [1:0] code);
        logic [2:0] len;
        unique case (code)
            WORD_FALSE: len = 3'd5;
            default:    len = 3'd4;
        endcase
        return len;
    endfunction

    // letter of an enum word at a position
    function automatic logic [7:0] word_char(input logic [1:0] code, input logic [2:0] pos);
        logic [7:0] ch;
        ch = CH_NUL;
        unique case (code)
            WORD_FALSE: begin
                unique case (pos)
                    3'd0:    ch = 8'h66;
                    3'd1:    ch = 8'h61;
                    3'd2:    ch = 8'h6c;
                    3'd3:    ch = 8'h73;
                    3'd4:    ch = 8'h65;
                    default: ch = CH_NUL;
                endcase
            end
            WORD_NULL: begin
                unique case (pos)
                    3'd0:    ch = 8'h6e;
                    3'd1:    ch = 8'h75;
                    3'd2:    ch = 8'h6c;
                    3'd3:    ch = 8'h6c;
                    default: ch = CH_NUL;
                endcase
            end
            default: begin
                unique case (pos)
                    3'd0:    ch = 8'h74;
                    3'd1:    ch = 8'h72;
                    3'd2:    ch = 8'h75;
                    3'd3:    ch = 8'h65;
                    default: ch = CH_NUL;
                endcase
            end
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/json_single_pair_parser.sv -----
// Top level of the single-pair JSON parser: byte input channel, result output channel.
// Holds the output register and the skid stage; the byte decisions sit in jsp_core.
// Depends on jsp_pkg and jsp_core.
//
//   channel  direction  handshake           payload
//   input    in         i_valid / o_stall   i_data_byte, i_final_byte
//   output   out        o_valid / i_stall   o_kind, o_payload, o_status, o_done_res
//
// One byte is accepted per cycle unless stalled; its result, if any, is registered in
// the output register or the skid stage. The state update is one pass through the
// parse state machine. Reset is synchronous and active low; it returns the parser to
// the brace phase and empties both output stages. A stalled output fills the skid
// stage, and the input is stalled only while the skid stage holds a result.
module json_single_pair_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_payload,
    output logic [2:0] o_status,
    output logic       o_done_res
);

    logic             accept;
    logic             res_valid;
    jsp_pkg::t_result res;

    logic             r_out_valid;
    jsp_pkg::t_result r_out;
    logic             r_skid_valid;
    jsp_pkg::t_result r_skid;
    logic             out_free;

    assign o_stall = r_skid_valid;
    assign accept  = i_valid & ~r_skid_valid;

    jsp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // output register is free when empty or its transfer completes
    assign out_free = ~r_out_valid | ~i_stall;

    // output register and skid valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid | res_valid;
            r_skid_valid <= 1'b0;
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // output and skid payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_kind     = r_out.kind;
    assign o_payload  = r_out.payload;
    assign o_status   = r_out.status;
    assign o_done_res = r_out.done_res;

endmodule

// ----- rtl/jsp_core.sv -----
// Parse state machine of the single-pair JSON parser.
// Decides each accepted byte combinationally and presents the result it causes.
// Depends on jsp_pkg.
module jsp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_final_byte,
    output logic             o_res_valid,
    output jsp_pkg::t_result o_res
);

    jsp_pkg::t_phase           r_phase, n_phase;
    logic [2:0]                r_match_pos, n_match_pos;
    logic [1:0]                r_enum_code, n_enum_code;
    logic [2:0]                r_esc_left, n_esc_left;
    logic [jsp_pkg::CNT_W-1:0] r_count, n_count;
    logic [2:0]                r_first_err, n_first_err;
    logic                      r_nul_seen, n_nul_seen;

    logic       fail_en;
    logic [2:0] fail_code;
    logic       str_ok;
    logic       emit;
    logic [1:0] emit_kind;
    logic [7:0] emit_pay;
    logic       in_esc;
    logic [1:0] word_sel;
    logic [2:0] word_next;
    logic [2:0] end_status;
    jsp_pkg::t_phase ph_body, ph_esc, ph_after, ph_step;
    logic [2:0] err_step;

    // byte decision
    always_comb begin
        ph_step     = r_phase;
        n_match_pos = r_match_pos;
        n_enum_code = r_enum_code;
        n_esc_left  = r_esc_left;
        n_count     = r_count;
        n_nul_seen  = r_nul_seen | (i_data_byte == jsp_pkg::CH_NUL);
        fail_en     = 1'b0;
        fail_code   = jsp_pkg::ST_OK;
        str_ok      = 1'b0;
        emit        = 1'b0;
        emit_kind   = jsp_pkg::KIND_NAME;
        emit_pay    = i_data_byte;
        word_sel    = (r_enum_code == jsp_pkg::WORD_NULL || r_enum_code == jsp_pkg::WORD_FALSE)
                      ? r_enum_code : jsp_pkg::WORD_TRUE;
        word_next   = r_match_pos + 3'd1;

        // string context: name or value
        in_esc   = (r_phase == jsp_pkg::PH_NAME_ESC) || (r_phase == jsp_pkg::PH_STR_ESC);
        if ((r_phase == jsp_pkg::PH_STR) || (r_phase == jsp_pkg::PH_STR_ESC)) begin
            ph_body  = jsp_pkg::PH_STR;
            ph_esc   = jsp_pkg::PH_STR_ESC;
            ph_after = jsp_pkg::PH_TRAIL;
        end else begin
            ph_body  = jsp_pkg::PH_NAME;
            ph_esc   = jsp_pkg::PH_NAME_ESC;
            ph_after = jsp_pkg::PH_COLON;
        end

        unique case (r_phase)
            jsp_pkg::PH_BRACE: begin
                if (i_data_byte == jsp_pkg::CH_LBRACE) begin
                    ph_step = jsp_pkg::PH_QUOTE;
                end else if (!jsp_pkg::is_ws(i_data_byte)) begin
                    fail_en   = 1'b1;
                    fail_code = jsp_pkg::ST_BAD_START;
                end
            end
            jsp_pkg::PH_QUOTE: begin
                if (i_data_byte == jsp_pkg::CH_QUOTE) begin
                    ph_step = jsp_pkg::PH_NAME;
                    n_count = '0;
                end else if (!jsp_pkg::is_ws(i_data_byte)) begin
                    fail_en   = 1'b1;
                    fail_code = jsp_pkg::ST_BAD_START;
                end
            end
            jsp_pkg::PH_NAME, jsp_pkg::PH_NAME_ESC,
            jsp_pkg::PH_STR, jsp_pkg::PH_STR_ESC: begin
                emit_kind = (ph_body == jsp_pkg::PH_STR) ? jsp_pkg::KIND_STRING
                                                         : jsp_pkg::KIND_NAME;
                if (in_esc) begin
                    if (r_esc_left == 3'd0) begin
                        if (jsp_pkg::is_single_esc(i_data_byte)) begin
                            ph_step = ph_body;
                            str_ok  = 1'b1;
                        end else if (i_data_byte == jsp_pkg::CH_U) begin
                            n_esc_left = 3'd4;
                            str_ok     = 1'b1;
                        end else begin
                            fail_en   = 1'b1;
                            fail_code = jsp_pkg::ST_BAD_STRING;
                        end
                    end else if (!jsp_pkg::is_hex(i_data_byte)) begin
                        fail_en   = 1'b1;
                        fail_code = jsp_pkg::ST_BAD_STRING;
                    end else begin
                        n_esc_left = r_esc_left - 3'd1;
                        if (r_esc_left == 3'd1) begin
                            ph_step = ph_body;
                        end
                        str_ok = 1'b1;
                    end
                end else if (i_data_byte == jsp_pkg::CH_QUOTE) begin
                    if (r_count == '0) begin
                        fail_en   = 1'b1;
                        fail_code = jsp_pkg::ST_BAD_STRING;
                    end else begin
                        ph_step = ph_after;
                    end
                end else if (i_data_byte < jsp_pkg::CH_SPACE) begin
                    fail_en   = 1'b1;
                    fail_code = jsp_pkg::ST_BAD_STRING;
                end else begin
                    if (i_data_byte == jsp_pkg::CH_BSLASH) begin
                        n_esc_left = 3'd0;
                        ph_step    = ph_esc;
                    end
                    str_ok = 1'b1;
                end
                // length cap on emitted bytes
                if (str_ok) begin
                    if (r_count >= jsp_pkg::CNT_W'(jsp_pkg::MAX_STRING_LEN)) begin
                        fail_en   = 1'b1;
                        fail_code = jsp_pkg::ST_BAD_STRING;
                    end else begin
                        n_count = r_count + jsp_pkg::CNT_W'(1);
                        emit    = 1'b1;
                    end
                end
            end
            jsp_pkg::PH_COLON: begin
                if (i_data_byte == jsp_pkg::CH_COLON) begin
                    ph_step = jsp_pkg::PH_VALUE;
                end else if (!jsp_pkg::is_ws(i_data_byte)) begin
                    fail_en   = 1'b1;
                    fail_code = jsp_pkg::ST_BAD_STRING;
                end
            end
            jsp_pkg::PH_VALUE: begin
                if (i_data_byte == jsp_pkg::CH_QUOTE) begin
                    ph_step = jsp_pkg::PH_STR;
                    n_count = '0;
                end else if (i_data_byte == jsp_pkg::CH_T) begin
                    n_enum_code = jsp_pkg::WORD_TRUE;
                    n_match_pos = 3'd1;
                    ph_step     = jsp_pkg::PH_WORD;
                end else if (i_data_byte == jsp_pkg::CH_F) begin
                    n_enum_code = jsp_pkg::WORD_FALSE;
                    n_match_pos = 3'd1;
                    ph_step     = jsp_pkg::PH_WORD;
                end else if (i_data_byte == jsp_pkg::CH_N) begin
                    n_enum_code = jsp_pkg::WORD_NULL;
                    n_match_pos = 3'd1;
                    ph_step     = jsp_pkg::PH_WORD;
                end else if (!jsp_pkg::is_ws(i_data_byte)) begin
                    fail_en   = 1'b1;
                    fail_code = jsp_pkg::ST_BAD_ENUM;
                end
            end
            jsp_pkg::PH_WORD: begin
                if ((r_match_pos >= jsp_pkg::word_len(word_sel)) ||
                    (jsp_pkg::word_char(word_sel, r_match_pos) != i_data_byte)) begin
                    fail_en   = 1'b1;
                    fail_code = jsp_pkg::ST_BAD_ENUM;
                end else begin
                    n_match_pos = word_next;
                    if (word_next == jsp_pkg::word_len(word_sel)) begin
                        emit      = 1'b1;
                        emit_kind = jsp_pkg::KIND_ENUM;
                        emit_pay  = {6'd0, word_sel};
                        ph_step   = jsp_pkg::PH_TRAIL;
                    end
                end
            end
            jsp_pkg::PH_TRAIL: begin
                if ((i_data_byte == jsp_pkg::CH_RBRACE) || (i_data_byte == jsp_pkg::CH_COMMA)) begin
                    ph_step = jsp_pkg::PH_DONE;
                end else if (!jsp_pkg::is_ws(i_data_byte)) begin
                    fail_en   = 1'b1;
                    fail_code = jsp_pkg::ST_BAD_TRAIL;
                end
            end
            default: begin
                // done or error: bytes do not change the phase, but a NUL byte is still recorded
            end
        endcase

        // first error is kept
        err_step = r_first_err;
        if (fail_en) begin
            ph_step = jsp_pkg::PH_ERROR;
            if (r_first_err == jsp_pkg::ST_OK) begin
                err_step = fail_code;
            end
        end
        n_phase     = ph_step;
        n_first_err = err_step;
    end

    // status at the final byte
    always_comb begin
        if (n_nul_seen) begin
            end_status = jsp_pkg::ST_MISC;
        end else begin
            unique case (ph_step)
                jsp_pkg::PH_ERROR:                      end_status = err_step;
                jsp_pkg::PH_DONE:                       end_status = jsp_pkg::ST_OK;
                jsp_pkg::PH_BRACE, jsp_pkg::PH_QUOTE:   end_status = jsp_pkg::ST_BAD_START;
                jsp_pkg::PH_VALUE, jsp_pkg::PH_WORD:    end_status = jsp_pkg::ST_BAD_ENUM;
                jsp_pkg::PH_TRAIL:                      end_status = jsp_pkg::ST_BAD_TRAIL;
                default:                                end_status = jsp_pkg::ST_BAD_STRING;
            endcase
        end
    end

    // result of this byte
    always_comb begin
        o_res_valid = i_accept & (i_final_byte | emit);
        if (i_final_byte) begin
            o_res.kind     = jsp_pkg::KIND_STATUS;
            o_res.payload  = 8'd0;
            o_res.status   = end_status;
            o_res.done_res = 1'b1;
        end else begin
            o_res.kind     = emit_kind;
            o_res.payload  = emit_pay;
            o_res.status   = jsp_pkg::ST_OK;
            o_res.done_res = 1'b0;
        end
    end

    // parse state, back to reset after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_final_byte)) begin
            r_phase     <= jsp_pkg::PH_BRACE;
            r_match_pos <= 3'd0;
            r_enum_code <= jsp_pkg::WORD_TRUE;
            r_esc_left  <= 3'd0;
            r_count     <= '0;
            r_first_err <= jsp_pkg::ST_OK;
            r_nul_seen  <= 1'b0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_match_pos <= n_match_pos;
            r_enum_code <= n_enum_code;
            r_esc_left  <= n_esc_left;
            r_count     <= n_count;
            r_first_err <= n_first_err;
            r_nul_seen  <= n_nul_seen;
        end
    end

endmodule
